>>> design/pracl_pkg.sv
// Shared types, constants and helpers for the port range access control list matcher.
package pracl_pkg;

   localparam int RuleEntries  = 64;
   localparam int DomainIdBits = 8;
   localparam int PortBits     = 16;
   localparam int DomainInBits = 8;
   localparam int CountBits    = $clog2(RuleEntries + 1);
   localparam int IndexBits    = (RuleEntries > 1) ? $clog2(RuleEntries) : 1;
   localparam int CsrIndexBits = 2;

   localparam logic [CsrIndexBits-1:0] CsrCheckEnabled = 2'd0;
   localparam logic [CsrIndexBits-1:0] CsrEnforceMode  = 2'd1;
   localparam logic [CsrIndexBits-1:0] CsrLearnMode    = 2'd2;

   localparam logic ModeCheck = 1'b0;
   localparam logic ModeAdd   = 1'b1;

   typedef enum logic [1:0] {
      StatusOk       = 2'd0,
      StatusDenied   = 2'd1,
      StatusFull     = 2'd2,
      StatusInverted = 2'd3
   } status_type;

   typedef logic [DomainIdBits-1:0] dom_type;
   typedef logic [PortBits-1:0]     port_type;
   typedef logic [CountBits-1:0]    count_type;

   typedef struct packed {
      dom_type  dom;
      logic     tcp;
      port_type lo;
      port_type hi;
   } rule_type;

   // Search token that walks down the row of rule cells.
   typedef struct packed {
      logic      valid;
      dom_type   dom;
      logic      tcp;
      port_type  lo;
      port_type  hi;
      count_type remain;
      logic      hit;
   } query_type;

   // Keeps the low DomainIdBits bits of the domain field, zero-extending if wider.
   function automatic dom_type to_dom(input logic [DomainInBits-1:0] d);
      logic [DomainInBits+16-1:0] w;
      w = {16'b0, d};
      return w[DomainIdBits-1:0];
   endfunction

endpackage

>>> design/pracl_ifs.sv
// Valid/ready channel interfaces for requests and responses.
interface pracl_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [pracl_pkg::DomainInBits-1:0] domain_id;
   logic       domain_trusted;
   logic       is_tcp;
   logic [pracl_pkg::PortBits-1:0] port_low;
   logic [pracl_pkg::PortBits-1:0] port_high;

   modport source (output valid, mode, domain_id, domain_trusted, is_tcp, port_low,
                   port_high, input ready);
   modport sink (input valid, mode, domain_id, domain_trusted, is_tcp, port_low,
                 port_high, output ready);
endinterface

interface pracl_rsp_if;
   logic       valid;
   logic       ready;
   logic       granted;
   logic [1:0] status;
   logic       entry_added;

   modport source (output valid, granted, status, entry_added, input ready);
   modport sink (input valid, granted, status, entry_added, output ready);
endinterface

>>> design/pracl_cell.sv
// One rule cell: holds a single rule and passes the search token on to its neighbour.
module pracl_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_stb,
   input  pracl_pkg::rule_type   wr_rule,
   input  pracl_pkg::query_type  q_in,
   output pracl_pkg::query_type  q_out
);

   pracl_pkg::rule_type  rule_ff;
   pracl_pkg::query_type q_ff;
   pracl_pkg::query_type q_in_next;
   logic                 live;
   logic                 match;

   // A cell is live only while the token still has rules left to visit, so an
   // unwritten cell is never compared.
   assign live  = (q_in.remain != '0);
   assign match = live && (rule_ff.dom == q_in.dom) && (rule_ff.tcp == q_in.tcp)
                  && (rule_ff.lo <= q_in.lo) && (q_in.hi <= rule_ff.hi);

   always_comb begin
      q_in_next = q_in;
      if (live) begin
         q_in_next.remain = q_in.remain - pracl_pkg::count_type'(1);
      end
      q_in_next.hit = q_in.hit | match;
   end

   always_ff @(posedge clock) begin
      if (wr_stb) begin
         rule_ff <= wr_rule;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else begin
         q_ff.valid <= q_in_next.valid;
      end
      q_ff.dom    <= q_in_next.dom;
      q_ff.tcp    <= q_in_next.tcp;
      q_ff.lo     <= q_in_next.lo;
      q_ff.hi     <= q_in_next.hi;
      q_ff.remain <= q_in_next.remain;
      q_ff.hit    <= q_in_next.hit;
   end

   assign q_out = q_ff;

endmodule

>>> design/port_range_acl_matcher.sv
// Port range access control list matcher: a row of rule cells searched by a travelling token.
// A request is captured, its token then walks every rule cell, and the verdict is registered.
// A new request is taken only in idle, once the previous search has reached its verdict.
// A new request is taken while the previous response still waits to be transferred.
// Synchronous active-high reset empties the table and clears the three control registers.
module port_range_acl_matcher (
   input  logic                                 clock,
   input  logic                                 reset,
   pracl_req_if.sink                            req_chan,
   pracl_rsp_if.source                          rsp_chan,
   input  logic                                 csr_we,
   input  logic [pracl_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic                                 csr_wdata
);

   typedef enum logic [2:0] {
      StIdle   = 3'b001,
      StSearch = 3'b010,
      StFinish = 3'b100
   } state_type;

   state_type                 state_ff, state_in;
   pracl_pkg::count_type      count_ff, count_in;
   logic                      check_en_ff, enforce_ff, learn_ff;

   logic                      mode_ff, trusted_ff, tcp_ff, hit_ff;
   pracl_pkg::dom_type        dom_ff;
   pracl_pkg::port_type       lo_ff, hi_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_granted_ff;
   pracl_pkg::status_type     rsp_status_ff;
   logic                      rsp_added_ff;

   pracl_pkg::query_type      inject_ff;
   pracl_pkg::query_type      chain_q [pracl_pkg::RuleEntries+1];
   logic [pracl_pkg::RuleEntries-1:0] wr_stb;
   pracl_pkg::rule_type       wr_rule;

   logic                      req_xfer;
   logic                      fire;
   logic                      full;
   logic                      grant_d, append_d;
   pracl_pkg::status_type     status_d;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == StIdle);
   assign full = (count_ff == pracl_pkg::CountBits'(pracl_pkg::RuleEntries));
   assign fire = (state_ff == StFinish) && (!rsp_valid_ff || rsp_chan.ready);

   // Decision once the token has visited every stored rule.
   always_comb begin
      grant_d  = 1'b0;
      append_d = 1'b0;
      status_d = pracl_pkg::StatusOk;
      if (mode_ff == pracl_pkg::ModeCheck) begin
         if (!check_en_ff || trusted_ff || hit_ff) begin
            grant_d = 1'b1;
         end else if (enforce_ff) begin
            status_d = pracl_pkg::StatusDenied;
         end else begin
            grant_d  = 1'b1;
            append_d = learn_ff && !full;
         end
      end else begin
         if (lo_ff > hi_ff) begin
            status_d = pracl_pkg::StatusInverted;
         end else if (hit_ff) begin
            grant_d = 1'b1;
         end else if (!full) begin
            grant_d  = 1'b1;
            append_d = 1'b1;
         end else begin
            status_d = pracl_pkg::StatusFull;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: begin
            if (req_xfer) begin
               state_in = StSearch;
            end
         end
         StSearch: begin
            if (chain_q[pracl_pkg::RuleEntries].valid) begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            if (fire) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (fire && append_d) begin
         count_in = count_ff + pracl_pkg::count_type'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= StIdle;
         count_ff        <= '0;
         check_en_ff     <= 1'b0;
         enforce_ff      <= 1'b0;
         learn_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               pracl_pkg::CsrCheckEnabled: check_en_ff <= csr_wdata;
               pracl_pkg::CsrEnforceMode:  enforce_ff  <= csr_wdata;
               pracl_pkg::CsrLearnMode:    learn_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Request capture, token launch, hit capture and response registers; a check searches only port_low.
   always_ff @(posedge clock) begin
      if (reset) begin
         inject_ff.valid <= 1'b0;
      end else begin
         inject_ff.valid <= req_xfer;
      end
      if (req_xfer) begin
         mode_ff          <= req_chan.mode;
         trusted_ff       <= req_chan.domain_trusted;
         tcp_ff           <= req_chan.is_tcp;
         dom_ff           <= pracl_pkg::to_dom(req_chan.domain_id);
         lo_ff            <= req_chan.port_low;
         hi_ff            <= (req_chan.mode == pracl_pkg::ModeAdd) ? req_chan.port_high
                                                                   : req_chan.port_low;
         inject_ff.dom    <= pracl_pkg::to_dom(req_chan.domain_id);
         inject_ff.tcp    <= req_chan.is_tcp;
         inject_ff.lo     <= req_chan.port_low;
         inject_ff.hi     <= (req_chan.mode == pracl_pkg::ModeAdd) ? req_chan.port_high
                                                                   : req_chan.port_low;
         inject_ff.remain <= count_ff;
         inject_ff.hit    <= 1'b0;
      end
      if (state_ff == StSearch && chain_q[pracl_pkg::RuleEntries].valid) begin
         hit_ff <= chain_q[pracl_pkg::RuleEntries].hit;
      end
      if (fire) begin
         rsp_granted_ff <= grant_d;
         rsp_status_ff  <= status_d;
         rsp_added_ff   <= append_d;
      end
   end

   assign wr_rule = '{dom: dom_ff, tcp: tcp_ff, lo: lo_ff, hi: hi_ff};
   assign chain_q[0] = inject_ff;

   for (genvar i = 0; i < pracl_pkg::RuleEntries; i++) begin : g_cell
      assign wr_stb[i] = fire && append_d
                         && (count_ff[pracl_pkg::IndexBits-1:0] == pracl_pkg::IndexBits'(i));
      pracl_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_stb  (wr_stb[i]),
         .wr_rule (wr_rule),
         .q_in    (chain_q[i]),
         .q_out   (chain_q[i+1])
      );
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.granted     = rsp_granted_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_added = rsp_added_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pracl_pkg::CountBits'(pracl_pkg::RuleEntries))
      else $error("rule count exceeds table depth");

   a_added_granted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_added_ff |-> rsp_granted_ff)
      else $error("rule appended without a grant");

   a_token_in_search: assert property (@(posedge clock) disable iff (reset)
      chain_q[pracl_pkg::RuleEntries].valid |-> state_ff == StSearch)
      else $error("search token left the row outside a search");

   a_xfer_starts_search: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == StSearch && inject_ff.valid)
      else $error("request transfer did not launch a search");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && count_ff != $past(count_ff)
      |-> count_ff == $past(count_ff) + pracl_pkg::count_type'(1))
      else $error("rule count moved by other than one");

endmodule

>>> test/port_range_acl_matcher_tb.sv
// Self-checking testbench for the port range access control list matcher.
module port_range_acl_matcher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [pracl_pkg::CsrIndexBits-1:0] CsrUnused = 2'd3;
   localparam int   PhaseItems    = 108;
   localparam int   WatchdogLimit = 2000;

   typedef struct {
      logic                               mode;
      logic [pracl_pkg::DomainInBits-1:0] dom;
      logic                               trusted;
      logic                               tcp;
      pracl_pkg::port_type                lo;
      pracl_pkg::port_type                hi;
   } acl_request_type;

   typedef struct {
      logic                  granted;
      pracl_pkg::status_type status;
      logic                  added;
   } acl_verdict_type;

   // Mirror of the rule table and control bits, in transfer order.
   class acl_scoreboard;
      pracl_pkg::rule_type rules[pracl_pkg::RuleEntries];
      int                  rule_total;
      bit                  check_on;
      bit                  enforce_on;
      bit                  learn_on;
      acl_verdict_type     verdict_q[$];
      int                  failures;

      function void set_config(bit c, bit e, bit l);
         check_on   = c;
         enforce_on = e;
         learn_on   = l;
      endfunction

      function int outstanding();
         return verdict_q.size();
      endfunction

      function bit covers(pracl_pkg::dom_type d, logic t, pracl_pkg::port_type lo,
                          pracl_pkg::port_type hi);
         for (int i = 0; i < rule_total; i++) begin
            if (rules[i].dom == d && rules[i].tcp == t && rules[i].lo <= lo && hi <= rules[i].hi)
               return 1'b1;
         end
         return 1'b0;
      endfunction

      function bit append_rule(pracl_pkg::dom_type d, logic t, pracl_pkg::port_type lo,
                               pracl_pkg::port_type hi);
         if (rule_total >= pracl_pkg::RuleEntries)
            return 1'b0;
         rules[rule_total] = '{dom: d, tcp: t, lo: lo, hi: hi};
         rule_total++;
         return 1'b1;
      endfunction

      function void note_request(acl_request_type q);
         acl_verdict_type    v;
         pracl_pkg::dom_type d;
         v = '{granted: 1'b0, status: pracl_pkg::StatusOk, added: 1'b0};
         d = pracl_pkg::dom_type'(q.dom);
         if (q.mode == pracl_pkg::ModeCheck) begin
            if (!check_on || q.trusted || covers(d, q.tcp, q.lo, q.lo)) begin
               v.granted = 1'b1;
            end else if (enforce_on) begin
               v.status = pracl_pkg::StatusDenied;
            end else begin
               // Unmatched but not enforcing: granted, and learnt if there is room.
               v.granted = 1'b1;
               if (learn_on && append_rule(d, q.tcp, q.lo, q.lo))
                  v.added = 1'b1;
            end
         end else begin
            if (q.lo > q.hi) begin
               v.status = pracl_pkg::StatusInverted;
            end else if (covers(d, q.tcp, q.lo, q.hi)) begin
               v.granted = 1'b1;
            end else if (append_rule(d, q.tcp, q.lo, q.hi)) begin
               v.granted = 1'b1;
               v.added   = 1'b1;
            end else begin
               v.status = pracl_pkg::StatusFull;
            end
         end
         verdict_q.push_back(v);
      endfunction

      function void check_response(acl_verdict_type got);
         acl_verdict_type want;
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected response granted %0b status %0d entry_added %0b",
                     $time, got.granted, got.status, got.added);
            failures++;
            return;
         end
         want = verdict_q.pop_front();
         if (got.granted !== want.granted) begin
            $display("%0t: granted expected %0b actual %0b", $time, want.granted, got.granted);
            failures++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            failures++;
         end
         if (got.added !== want.added) begin
            $display("%0t: entry_added expected %0b actual %0b", $time, want.added, got.added);
            failures++;
         end
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic                               csr_we;
   logic [pracl_pkg::CsrIndexBits-1:0] csr_index;
   logic                               csr_wdata;

   pracl_req_if req_chan ();
   pracl_rsp_if rsp_chan ();

   acl_scoreboard sb = new();

   int burst_left  = 0;
   int ready_left  = 0;
   int ready_kind  = 0;
   int idle_cycles = 0;

   port_range_acl_matcher i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The receiver alternates between steady acceptance, random stalls and long holds.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_kind = $urandom_range(0, 9);
         ready_left = (ready_kind < 7) ? $urandom_range(10, 150) : $urandom_range(1, 90);
      end
      ready_left--;
      if (ready_kind < 4)
         rsp_chan.ready <= 1'b1;
      else if (ready_kind < 7)
         rsp_chan.ready <= ($urandom_range(0, 2) != 0);
      else
         rsp_chan.ready <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_response('{granted: rsp_chan.granted,
                             status:  pracl_pkg::status_type'(rsp_chan.status),
                             added:   rsp_chan.entry_added});
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("port_range_acl_matcher regression: fail");
         $finish;
      end
   end

   function automatic acl_request_type make_request(logic mode,
                                                    logic [pracl_pkg::DomainInBits-1:0] dom,
                                                    logic trusted, logic tcp,
                                                    pracl_pkg::port_type lo,
                                                    pracl_pkg::port_type hi);
      acl_request_type q;
      q = '{mode: mode, dom: dom, trusted: trusted, tcp: tcp, lo: lo, hi: hi};
      return q;
   endfunction

   // Mostly aims at existing rules and their edges, so that matches and misses both occur.
   function automatic acl_request_type random_request();
      acl_request_type     q;
      pracl_pkg::rule_type r;
      int                  sel;
      int                  span;
      q.mode    = ($urandom_range(0, 99) < 25) ? pracl_pkg::ModeAdd : pracl_pkg::ModeCheck;
      q.trusted = ($urandom_range(0, 9) == 0);
      q.tcp     = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 9);
      if (sel < 5)
         q.dom = pracl_pkg::DomainInBits'($urandom_range(0, 3));
      else if (sel < 7)
         q.dom = pracl_pkg::DomainInBits'(8'hFF - $urandom_range(0, 1));
      else
         q.dom = pracl_pkg::DomainInBits'($urandom_range(0, 255));
      q.lo = pracl_pkg::port_type'($urandom_range(0, 65535));
      q.hi = pracl_pkg::port_type'($urandom_range(0, 65535));
      sel = $urandom_range(0, 9);
      if (sb.rule_total > 0 && sel < 6) begin
         r = sb.rules[$urandom_range(0, sb.rule_total - 1)];
         q.dom = r.dom;
         if ($urandom_range(0, 4) != 0)
            q.tcp = r.tcp;
         case ($urandom_range(0, 4))
            0: q.lo = r.lo - 16'd1;
            1: q.lo = r.lo;
            2: q.lo = r.hi;
            3: q.lo = r.hi + 16'd1;
            default: q.lo = pracl_pkg::port_type'(r.lo + $urandom_range(0, r.hi - r.lo));
         endcase
      end else if (sel == 6) begin
         q.lo = '0;
      end else if (sel == 7) begin
         q.lo = '1;
      end
      if (q.mode == pracl_pkg::ModeAdd) begin
         sel = $urandom_range(0, 9);
         if (sel < 2) begin
            q.hi = q.lo;
         end else if (sel < 7) begin
            span = int'(q.lo) + $urandom_range(0, 400);
            q.hi = (span > 65535) ? 16'hFFFF : pracl_pkg::port_type'(span);
         end else if (sel == 7) begin
            q.hi = pracl_pkg::port_type'(q.lo - 1 - $urandom_range(0, 50));
         end
      end
      return q;
   endfunction

   task automatic send_request(acl_request_type q);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 9);
         if (gap < 4)
            gap = 0;
         else if (gap < 8)
            gap = $urandom_range(1, 8);
         else
            gap = $urandom_range(40, 140);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid          <= 1'b1;
      req_chan.mode           <= q.mode;
      req_chan.domain_id      <= q.dom;
      req_chan.domain_trusted <= q.trusted;
      req_chan.is_tcp         <= q.tcp;
      req_chan.port_low       <= q.lo;
      req_chan.port_high      <= q.hi;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      sb.note_request(q);
   endtask

   // Lets every outstanding response drain so that the block is idle.
   task automatic finish_phase();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (sb.outstanding() != 0)
         @(posedge clock);
   endtask

   task automatic apply_config(bit c, bit e, bit l);
      csr_we    <= 1'b1;
      csr_index <= pracl_pkg::CsrCheckEnabled;
      csr_wdata <= c;
      @(posedge clock);
      csr_index <= pracl_pkg::CsrEnforceMode;
      csr_wdata <= e;
      @(posedge clock);
      csr_index <= pracl_pkg::CsrLearnMode;
      csr_wdata <= l;
      @(posedge clock);
      // A write to the unused index must leave every register as it was.
      csr_index <= CsrUnused;
      csr_wdata <= 1'($urandom_range(0, 1));
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_config(c, e, l);
   endtask

   // Phase settings as {check_enabled, enforce_mode, learn_mode}.
   bit [2:0] phase_cfg[10] = '{3'b110, 3'b000, 3'b111, 3'b100, 3'b101,
                               3'b010, 3'b110, 3'b001, 3'b101, 3'b111};

   initial begin
      reset                   <= 1'b1;
      csr_we                  <= 1'b0;
      csr_index               <= pracl_pkg::CsrCheckEnabled;
      csr_wdata               <= 1'b0;
      req_chan.valid          <= 1'b0;
      req_chan.mode           <= pracl_pkg::ModeCheck;
      req_chan.domain_id      <= '0;
      req_chan.domain_trusted <= 1'b0;
      req_chan.is_tcp         <= 1'b0;
      req_chan.port_low       <= '0;
      req_chan.port_high      <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Checking off after reset: checks are granted, the inverted add is refused; the other adds build a few rules.
      send_request(make_request(pracl_pkg::ModeCheck, 8'h5A, 1'b0, 1'b1, 16'd80, 16'hFFFF));
      send_request(make_request(pracl_pkg::ModeAdd, 8'h00, 1'b0, 1'b1, 16'd100, 16'd200));
      send_request(make_request(pracl_pkg::ModeAdd, 8'h00, 1'b0, 1'b1, 16'd5, 16'd4));
      send_request(make_request(pracl_pkg::ModeAdd, 8'h00, 1'b1, 1'b1, 16'd150, 16'd160));
      send_request(make_request(pracl_pkg::ModeAdd, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'hFFFF));
      send_request(make_request(pracl_pkg::ModeAdd, 8'h00, 1'b0, 1'b1, 16'd100, 16'd201));
      finish_phase();

      // Enforcing: range edges, protocol and domain mismatch, trusted override.
      apply_config(1'b1, 1'b1, 1'b0);
      send_request(make_request(pracl_pkg::ModeCheck, 8'h00, 1'b0, 1'b1, 16'd100, 16'd0));
      send_request(make_request(pracl_pkg::ModeCheck, 8'h00, 1'b0, 1'b1, 16'd201, 16'd0));
      send_request(make_request(pracl_pkg::ModeCheck, 8'h00, 1'b0, 1'b1, 16'd99, 16'd0));
      send_request(make_request(pracl_pkg::ModeCheck, 8'h00, 1'b0, 1'b0, 16'd150, 16'd0));
      send_request(make_request(pracl_pkg::ModeCheck, 8'h01, 1'b0, 1'b1, 16'd150, 16'd0));
      send_request(make_request(pracl_pkg::ModeCheck, 8'h01, 1'b1, 1'b1, 16'd150, 16'd0));
      send_request(make_request(pracl_pkg::ModeCheck, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'd0));
      send_request(make_request(pracl_pkg::ModeCheck, 8'hFF, 1'b0, 1'b0, 16'hFFFF, 16'd0));
      send_request(make_request(pracl_pkg::ModeAdd, 8'h80, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF));
      send_request(make_request(pracl_pkg::ModeAdd, 8'h7F, 1'b0, 1'b1, 16'h0000, 16'h0000));
      finish_phase();

      // Permissive without learning: granted, nothing appended.
      apply_config(1'b1, 1'b0, 1'b0);
      send_request(make_request(pracl_pkg::ModeCheck, 8'h03, 1'b0, 1'b0, 16'd443, 16'd0));
      finish_phase();

      // Learning: the first miss is appended, the repeat then matches it.
      apply_config(1'b1, 1'b0, 1'b1);
      send_request(make_request(pracl_pkg::ModeCheck, 8'h03, 1'b0, 1'b0, 16'd443, 16'd0));
      send_request(make_request(pracl_pkg::ModeCheck, 8'h03, 1'b0, 1'b0, 16'd443, 16'd0));
      send_request(make_request(pracl_pkg::ModeCheck, 8'h03, 1'b1, 1'b1, 16'd443, 16'd0));
      finish_phase();

      apply_config(1'b0, 1'b1, 1'b1);
      send_request(make_request(pracl_pkg::ModeCheck, 8'h09, 1'b0, 1'b1, 16'd9, 16'd9));
      finish_phase();

      // The table fills during these phases, so the full-table cases follow naturally.
      for (int p = 0; p < 10; p++) begin
         apply_config(phase_cfg[p][2], phase_cfg[p][1], phase_cfg[p][0]);
         for (int n = 0; n < PhaseItems; n++)
            send_request(random_request());
         finish_phase();
      end

      // Catch any response that arrives without a matching request.
      repeat (pracl_pkg::RuleEntries + 16) @(posedge clock);
      if (sb.failures == 0)
         $display("port_range_acl_matcher regression: pass");
      else
         $display("port_range_acl_matcher regression: fail");
      $finish;
   end

endmodule
